// ===== design/sat_pkg.sv =====
// Shared types and constants for the sorted array table.
// No dependencies; used by sat_cell and sorted_array_table.
package sat_pkg;

	localparam int Depth     = 8;
	localparam int ValueBits = 32;
	localparam int PosBits   = 3;
	localparam int CountBits = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] operand_value;
	} req_item_t;

	typedef struct packed {
		status_t                status;
		logic [PosBits-1:0]     position;
		logic [CountBits-1:0]   entry_count;
	} rsp_item_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                        do_insert;
		logic                        do_remove;
		logic signed [ValueBits-1:0] key;
	} cell_cmd_t;

	// Per-cell compare results, already qualified by the occupied flag.
	typedef struct packed {
		logic le;
		logic eq;
	} cell_flags_t;

endpackage

// ===== design/sat_cell.sv =====
// One storage cell of the sorted array table: holds one entry, compares it
// with the broadcast key and shifts with its neighbors. Depends on sat_pkg.
module sat_cell (
	input  logic                                 clk,
	input  sat_pkg::cell_cmd_t                   cmd,
	input  logic                                 occupied,
	input  logic signed [sat_pkg::ValueBits-1:0] left_entry,
	input  logic signed [sat_pkg::ValueBits-1:0] right_entry,
	input  logic                                 left_le,
	input  logic                                 hit_in,
	output logic signed [sat_pkg::ValueBits-1:0] entry,
	output sat_pkg::cell_flags_t                 flags,
	output logic                                 hit_out
);

	logic signed [sat_pkg::ValueBits-1:0] entry_q;

	assign entry    = entry_q;
	assign flags.le = occupied && (entry_q <= cmd.key);
	assign flags.eq = occupied && (entry_q == cmd.key);
	assign hit_out  = hit_in | flags.eq;

	// Insert: cells above the insertion point take the left neighbor's entry,
	// the insertion point takes the key. Remove: the matching cell and all
	// above it take the right neighbor's entry.
	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			if (!left_le) begin
				entry_q <= left_entry;
			end else if (!flags.le) begin
				entry_q <= cmd.key;
			end
		end else if (cmd.do_remove && hit_out) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== design/sorted_array_table.sv =====
// Top level of the sorted array table: a row of sat_cell instances plus the
// fill count and the result register. Depends on sat_pkg and sat_cell.
//
// Usage:
//   Request channel (req_valid, req_ready, req) carries one item: an opcode
//   (insert, search, remove, or no operation) and a signed value. Response
//   channel (rsp_valid, rsp_ready, rsp) returns one item per request with a
//   status, the position inserted, found or removed, and the entry count
//   after the operation.
//   All cells compare their entry with the value in parallel and shift in
//   the same cycle: the response appears the cycle after the request is
//   accepted, and a new request can be taken every cycle unless a stalled
//   response holds req_ready low. The clock period is set by the compare of
//   each cell plus the short match chain that runs along the row.
//   Duplicates: insert goes after the last equal entry; search and remove
//   use the lowest matching index. An insert into a full table changes
//   nothing and reports full; a missed search or remove reports not found.
//   Reset clears the fill count and the response valid flag; entry contents
//   are not cleared, since only entries below the count are ever looked at.
//   If the receiver stalls, the response register holds its item and
//   req_ready drops until that item is taken; no item is lost.
module sorted_array_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sat_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sat_pkg::rsp_item_t rsp
);

	logic [sat_pkg::CountBits-1:0]        count_q;
	logic                                 rsp_valid_q;
	sat_pkg::rsp_item_t                   rsp_q;

	logic                                 accept;
	logic                                 full;
	logic                                 found;
	sat_pkg::cell_cmd_t                   cmd;
	logic [sat_pkg::Depth-1:0]            occupied;
	logic signed [sat_pkg::ValueBits-1:0] entries [sat_pkg::Depth];
	sat_pkg::cell_flags_t                 flags   [sat_pkg::Depth];
	logic [sat_pkg::Depth-1:0]            hits;
	logic [sat_pkg::PosBits-1:0]          ins_pos;
	logic [sat_pkg::PosBits-1:0]          match_pos;
	sat_pkg::rsp_item_t                   rsp_next;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full  = (count_q == sat_pkg::CountBits'(sat_pkg::Depth));
	assign found = hits[sat_pkg::Depth-1];

	// A cell is occupied when its index lies below the fill count.
	always_comb begin
		for (int i = 0; i < sat_pkg::Depth; i++) begin
			occupied[i] = (count_q > sat_pkg::CountBits'(i));
		end
	end

	always_comb begin
		cmd.key       = req.operand_value;
		cmd.do_insert = accept && (req.opcode == sat_pkg::OP_INSERT) && !full;
		cmd.do_remove = accept && (req.opcode == sat_pkg::OP_REMOVE) && found;
	end

	// The insertion point is the number of occupied entries not above the key;
	// since the row is sorted, that is the first cell whose le flag is low.
	always_comb begin
		ins_pos = sat_pkg::PosBits'(sat_pkg::Depth - 1);
		for (int i = sat_pkg::Depth - 1; i >= 0; i--) begin
			if (!flags[i].le) begin
				ins_pos = sat_pkg::PosBits'(i);
			end
		end
	end

	// Lowest matching index.
	always_comb begin
		match_pos = '0;
		for (int i = sat_pkg::Depth - 1; i >= 0; i--) begin
			if (flags[i].eq) begin
				match_pos = sat_pkg::PosBits'(i);
			end
		end
	end

	generate
		for (genvar g = 0; g < sat_pkg::Depth; g++) begin : g_cell
			logic signed [sat_pkg::ValueBits-1:0] left_entry;
			logic signed [sat_pkg::ValueBits-1:0] right_entry;
			logic                                 left_le;
			logic                                 hit_in;

			if (g == 0) begin : g_first
				assign left_entry = req.operand_value;
				assign left_le    = 1'b1;
				assign hit_in     = 1'b0;
			end else begin : g_rest
				assign left_entry = entries[g-1];
				assign left_le    = flags[g-1].le;
				assign hit_in     = hits[g-1];
			end

			if (g == sat_pkg::Depth - 1) begin : g_last
				assign right_entry = entries[g];
			end else begin : g_inner
				assign right_entry = entries[g+1];
			end

			sat_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occupied[g]),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.left_le     (left_le),
				.hit_in      (hit_in),
				.entry       (entries[g]),
				.flags       (flags[g]),
				.hit_out     (hits[g])
			);
		end
	endgenerate

	// Result of the accepted item, with the count as it stands afterwards.
	always_comb begin
		rsp_next.status      = sat_pkg::ST_OK;
		rsp_next.position    = '0;
		rsp_next.entry_count = count_q;
		unique case (req.opcode)
			sat_pkg::OP_INSERT: begin
				if (full) begin
					rsp_next.status = sat_pkg::ST_FULL;
				end else begin
					rsp_next.position    = ins_pos;
					rsp_next.entry_count = count_q + 1'b1;
				end
			end
			sat_pkg::OP_SEARCH: begin
				if (found) begin
					rsp_next.position = match_pos;
				end else begin
					rsp_next.status = sat_pkg::ST_NOT_FOUND;
				end
			end
			sat_pkg::OP_REMOVE: begin
				if (found) begin
					rsp_next.position    = match_pos;
					rsp_next.entry_count = count_q - 1'b1;
				end else begin
					rsp_next.status = sat_pkg::ST_NOT_FOUND;
				end
			end
			sat_pkg::OP_NOP: begin
				rsp_next.status = sat_pkg::ST_OK;
			end
			default: begin
				rsp_next.status = sat_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= rsp_next.entry_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

endmodule
